// ===== rtl/bbcm_pkg.sv =====
// ----------------------------------------------------------------------------
// bbcm_pkg
// shared types, codes and constants of the block buffer cache manager
// ----------------------------------------------------------------------------
package bbcm_pkg;

	localparam int NUM_ENTRIES_DEF = 32;
	localparam int DEV_W = 16;
	localparam int BLK_W = 16;
	localparam int REF_W = 8;
	localparam int IDX_W = 5;
	localparam int IN_TDATA_W = 41;
	localparam int OUT_TDATA_W = 42;

	typedef enum logic [1:0] {
		MODE_GET     = 2'd0,
		MODE_RELEASE = 2'd1,
		MODE_FLAGS   = 2'd2,
		MODE_SYNC    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		KIND_GRANT   = 3'd0,
		KIND_WBACK   = 3'd1,
		KIND_NOFREE  = 3'd2,
		KIND_RELERR  = 3'd3,
		KIND_DONE    = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT,
		ST_VICT,
		ST_WB,
		ST_FINAL,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request
		logic clr_scan;  // reset scan index
		logic step;      // advance scan index
		logic do_hit;    // apply hit update
		logic take_vict; // remember victim, claim it, set up queue rotation
		logic wb_emit;   // emit writeback at scan index, clear dirty
		logic finish;    // do final update and emit last result
		logic shift;     // one queue shift step
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;   // scan index at last entry
		logic hit_match;  // entry at scan index hits
		logic free_match; // queue entry at scan index is free
		logic wb_match;   // entry at scan index needs writeback
		logic vict_dirty; // chosen victim dirty
		logic shift_done; // queue rotation complete
		logic out_busy;   // output register full and not taken
		logic is_get;
		logic is_sync;
	} sts_t;

endpackage

// ===== rtl/bbcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbcm_ctrl
// sequencer for the tag scans, victim search and writeback sweeps
// ----------------------------------------------------------------------------
module bbcm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_fire,
	input  bbcm_pkg::sts_t  sts,
	output logic            idle,
	output bbcm_pkg::cmd_t  cmd
);
	import bbcm_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) begin
				if (sts.is_get) state_d = ST_HIT;
				else if (sts.is_sync) state_d = ST_WB;
				else state_d = ST_FINAL;
			end
			ST_HIT: begin
				// a hit is the last result, wait for a free output register
				if (sts.hit_match) begin
					if (!sts.out_busy) state_d = ST_IDLE;
				end else if (sts.scan_end) state_d = ST_VICT;
			end
			ST_VICT: begin
				if (sts.free_match) state_d = ST_OUT;
				else if (sts.scan_end) state_d = ST_FINAL;
			end
			ST_OUT: begin
				// queue rotation runs here, then writeback sweep if dirty
				if (sts.shift_done) state_d = sts.vict_dirty ? ST_WB : ST_FINAL;
			end
			ST_WB: if (!sts.out_busy && sts.scan_end) state_d = ST_FINAL;
			ST_FINAL: if (!sts.out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_fire;
				cmd.clr_scan = in_fire;
			end
			ST_HIT: begin
				cmd.do_hit = sts.hit_match && !sts.out_busy;
				cmd.step = !sts.hit_match && !sts.scan_end;
				cmd.clr_scan = !sts.hit_match && sts.scan_end;
			end
			ST_VICT: begin
				cmd.take_vict = sts.free_match;
				cmd.step = !sts.free_match && !sts.scan_end;
			end
			ST_OUT: begin
				cmd.shift = !sts.shift_done;
				cmd.clr_scan = sts.shift_done;
			end
			ST_WB: if (!sts.out_busy) begin
				cmd.wb_emit = sts.wb_match;
				cmd.step = !sts.scan_end;
			end
			ST_FINAL: cmd.finish = !sts.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== rtl/bbcm_dp.sv =====
// ----------------------------------------------------------------------------
// bbcm_dp
// tag store, flags, reference counts, allocation queue and output register
// ----------------------------------------------------------------------------
module bbcm_dp #(
	parameter int NUM_ENTRIES = bbcm_pkg::NUM_ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [bbcm_pkg::IN_TDATA_W-1:0]    in_data,
	input  bbcm_pkg::cmd_t                     cmd,
	output bbcm_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [bbcm_pkg::OUT_TDATA_W-1:0]   out_data,
	output logic                               out_last
);
	import bbcm_pkg::*;

	localparam int SW = $clog2(NUM_ENTRIES);

	logic [DEV_W-1:0] tdev_q [NUM_ENTRIES];
	logic [BLK_W-1:0] tblk_q [NUM_ENTRIES];
	logic [REF_W-1:0] ref_q  [NUM_ENTRIES];
	logic [NUM_ENTRIES-1:0] dirty_q, utd_q;
	logic [SW-1:0] aq_q [NUM_ENTRIES];

	logic [1:0] mode_q;
	logic [DEV_W-1:0] dev_q, wdev_q;
	logic [BLK_W-1:0] blk_q;
	logic [IDX_W-1:0] idx_q;
	logic dflag_q, vflag_q, all_q;
	logic [SW-1:0] scan_q, vict_q, shp_q;
	logic found_q;

	logic ov_q, olast_q;
	logic [OUT_TDATA_W-1:0] od_q;

	logic [SW-1:0] qe;
	logic in_rng;
	logic [SW-1:0] ix;

	assign qe = aq_q[scan_q];
	assign in_rng = ({1'b0, idx_q} < (IDX_W+1)'(NUM_ENTRIES));
	assign ix = SW'(idx_q);

	assign sts.scan_end = (scan_q == SW'(NUM_ENTRIES-1));
	assign sts.hit_match = (tdev_q[scan_q] != '0) && (tdev_q[scan_q] == dev_q)
		&& (tblk_q[scan_q] == blk_q);
	assign sts.free_match = (ref_q[qe] == '0);
	assign sts.wb_match = dirty_q[scan_q] && (all_q || tdev_q[scan_q] == wdev_q);
	assign sts.vict_dirty = dirty_q[vict_q];
	assign sts.shift_done = (shp_q == SW'(NUM_ENTRIES-1));
	assign sts.out_busy = ov_q && !out_ready;
	assign sts.is_get = (in_data[1:0] == MODE_GET);
	assign sts.is_sync = (in_data[1:0] == MODE_SYNC);

	assign out_valid = ov_q;
	assign out_data = od_q;
	assign out_last = olast_q;

	function automatic logic [OUT_TDATA_W-1:0] pack(kind_t k, logic [IDX_W-1:0] i,
		logic [DEV_W-1:0] d, logic [BLK_W-1:0] b, logic h, logic v);
		return {v, h, b, d, i, k};
	endfunction

	// registers with reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				tdev_q[i] <= '0;
				tblk_q[i] <= '0;
				ref_q[i] <= '0;
				aq_q[i] <= SW'(i);
			end
			dirty_q <= '0;
			utd_q <= '0;
		end else begin
			if (cmd.do_hit || cmd.wb_emit || cmd.finish) ov_q <= 1'b1;
			else if (ov_q && out_ready) ov_q <= 1'b0;
			if (cmd.do_hit && ref_q[scan_q] != '1) ref_q[scan_q] <= ref_q[scan_q] + 1'b1;
			if (cmd.take_vict) ref_q[qe] <= REF_W'(1);
			if (cmd.shift) begin
				aq_q[shp_q] <= aq_q[shp_q + 1'b1];
				aq_q[NUM_ENTRIES-1] <= (shp_q == SW'(NUM_ENTRIES-2)) ? vict_q
					: aq_q[NUM_ENTRIES-1];
			end
			if (cmd.wb_emit) dirty_q[scan_q] <= 1'b0;
			if (cmd.finish) begin
				case (mode_q)
					MODE_GET: if (found_q) begin
						tdev_q[vict_q] <= dev_q;
						tblk_q[vict_q] <= blk_q;
						dirty_q[vict_q] <= 1'b0;
						utd_q[vict_q] <= 1'b0;
					end
					MODE_RELEASE: if (in_rng && ref_q[ix] != '0)
						ref_q[ix] <= ref_q[ix] - 1'b1;
					MODE_FLAGS: if (in_rng) begin
						dirty_q[ix] <= dflag_q;
						utd_q[ix] <= vflag_q;
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_data[1:0];
			dev_q <= in_data[17:2];
			blk_q <= in_data[33:18];
			idx_q <= in_data[38:34];
			dflag_q <= in_data[39];
			vflag_q <= in_data[40];
			all_q <= (in_data[17:2] == '0);
			wdev_q <= in_data[17:2];
			found_q <= 1'b0;
		end
		if (cmd.clr_scan) scan_q <= '0;
		else if (cmd.step) scan_q <= scan_q + 1'b1;
		if (cmd.take_vict) begin
			vict_q <= qe;
			found_q <= 1'b1;
			wdev_q <= tdev_q[qe];
			all_q <= 1'b0;
			shp_q <= scan_q;
		end
		if (cmd.shift) shp_q <= shp_q + 1'b1;
		if (cmd.do_hit) begin
			od_q <= pack(KIND_GRANT, IDX_W'(scan_q), dev_q, blk_q, 1'b1, utd_q[scan_q]);
			olast_q <= 1'b1;
		end
		if (cmd.wb_emit) begin
			od_q <= pack(KIND_WBACK, IDX_W'(scan_q), tdev_q[scan_q], tblk_q[scan_q],
				1'b0, 1'b0);
			olast_q <= 1'b0;
		end
		if (cmd.finish) begin
			olast_q <= 1'b1;
			case (mode_q)
				MODE_GET: od_q <= found_q
					? pack(KIND_GRANT, IDX_W'(vict_q), dev_q, blk_q, 1'b0, 1'b0)
					: pack(KIND_NOFREE, '0, '0, '0, 1'b0, 1'b0);
				MODE_RELEASE: od_q <= (in_rng && ref_q[ix] != '0)
					? pack(KIND_DONE, '0, '0, '0, 1'b0, 1'b0)
					: pack(KIND_RELERR, '0, '0, '0, 1'b0, 1'b0);
				default: od_q <= pack(KIND_DONE, '0, '0, '0, 1'b0, 1'b0);
			endcase
		end
	end

endmodule

// ===== rtl/block_buffer_cache_manager.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_manager
// tag manager for a disk block cache: get, release, set flags, sync
// ----------------------------------------------------------------------------
// channel   dir  tdata                                    tuser / tlast
// s_axis    in   mode,device,block_number,entry_index,    -
//                dirty_flag,valid_data_flag (41 -> 48)
// m_axis    out  kind,result_index,result_device,         tlast = last
//                result_block,was_hit,holds_valid_data (42 -> 48)
//
// one request at a time; s_axis_tready is high only while idle
// a get hit is granted when the tag compare reaches it; the tag compare walks
// one entry per cycle
// a miss adds a queue search, a queue rotation and, for a dirty victim, a
// writeback sweep, then the grant; with no free entry it answers no free
// a sync runs a writeback sweep before its answer; release and set flags answer
// without a scan
// reset clears all tags, counts and marks at once
// output stalls hold the sweep in place; no result is dropped
module block_buffer_cache_manager #(
	parameter int NUM_ENTRIES = bbcm_pkg::NUM_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode, device, block_number, entry_index, dirty_flag, valid_data_flag
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind, result_index, result_device, result_block, was_hit, holds_valid_data
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import bbcm_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic idle, in_fire;
	logic [OUT_TDATA_W-1:0] od;
	logic [IN_TDATA_W-1:0] ind;

	// request taken only between requests
	assign s_axis_tready = idle;
	assign in_fire = s_axis_tvalid && idle;
	assign ind = s_axis_tdata[IN_TDATA_W-1:0];

	bbcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .sts(sts),
		.idle(idle), .cmd(cmd)
	);

	bbcm_dp #(.NUM_ENTRIES(NUM_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_data(ind),
		.cmd(cmd), .sts(sts), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(od), .out_last(m_axis_tlast)
	);

	// zero padding up to whole bytes
	assign m_axis_tdata = {{(48-OUT_TDATA_W){1'b0}}, od};

endmodule

// ===== rtl/bbcm_check.sv =====
// ----------------------------------------------------------------------------
// bbcm_check
// port-level checks of the block buffer cache manager
// ----------------------------------------------------------------------------
module bbcm_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// no second request taken straight after an accepted one
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted twice");

	// kind codes in range
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'd4)
		else $error("bad kind");

	// writebacks are never last
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == 3'd1 |-> !m_axis_tlast)
		else $error("writeback marked last");
endmodule

bind block_buffer_cache_manager bbcm_check u_check (.*);

// ===== dv/tb_block_buffer_cache_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_manager
// streams get, release, set-flag and sync requests into the cache manager,
// predicts every result from a local copy of the tag store and checks the
// output stream field by field, with random idle cycles on both sides
// ----------------------------------------------------------------------------

// holds the tag store copy and the queue of predicted results
class bbcm_scoreboard;
	localparam int N = bbcm_pkg::NUM_ENTRIES_DEF;

	logic [15:0] tag_dev [N];
	logic [15:0] tag_blk [N];
	logic [7:0]  refs [N];
	bit          dirty [N];
	bit          uptodate [N];
	int          order [N];
	logic [47:0] pending_data [$];
	bit          pending_last [$];
	int          errors;

	function new();
		errors = 0;
		for (int i = 0; i < N; i++) begin
			tag_dev[i] = '0;
			tag_blk[i] = '0;
			refs[i] = '0;
			dirty[i] = 1'b0;
			uptodate[i] = 1'b0;
			order[i] = i;
		end
	endfunction

	// pack one result the way the block drives m_axis_tdata
	function void push_result(bbcm_pkg::kind_t k, logic [4:0] idx, logic [15:0] dev,
			logic [15:0] blk, bit hit, bit vld, bit lst);
		logic [47:0] d;
		d = '0;
		d[2:0] = k;
		d[7:3] = idx;
		d[23:8] = dev;
		d[39:24] = blk;
		d[40] = hit;
		d[41] = vld;
		pending_data.push_back(d);
		pending_last.push_back(lst);
	endfunction

	function void flush_dirty(bit all, logic [15:0] dev);
		for (int i = 0; i < N; i++)
			if (dirty[i] && (all || tag_dev[i] == dev)) begin
				push_result(bbcm_pkg::KIND_WBACK, 5'(i), tag_dev[i], tag_blk[i],
					1'b0, 1'b0, 1'b0);
				dirty[i] = 1'b0;
			end
	endfunction

	// note one accepted request and predict what it causes
	function void note_request(logic [47:0] req);
		bbcm_pkg::mode_t m;
		logic [15:0] dev, blk;
		logic [4:0] idx;
		int pos, e;
		m = bbcm_pkg::mode_t'(req[1:0]);
		dev = req[17:2];
		blk = req[33:18];
		idx = req[38:34];
		case (m)
			bbcm_pkg::MODE_GET: begin
				for (int i = 0; i < N; i++)
					if (tag_dev[i] != 0 && tag_dev[i] == dev && tag_blk[i] == blk) begin
						if (refs[i] != 8'hff) refs[i]++;
						push_result(bbcm_pkg::KIND_GRANT, 5'(i), dev, blk, 1'b1,
							uptodate[i], 1'b1);
						return;
					end
				pos = -1;
				for (int p = 0; p < N; p++)
					if (pos < 0 && refs[order[p]] == 0) pos = p;
				if (pos < 0) begin
					push_result(bbcm_pkg::KIND_NOFREE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
					return;
				end
				e = order[pos];
				for (int p = pos; p < N - 1; p++) order[p] = order[p + 1];
				order[N - 1] = e;
				refs[e] = 8'd1;
				if (dirty[e]) flush_dirty(1'b0, tag_dev[e]);
				tag_dev[e] = dev;
				tag_blk[e] = blk;
				dirty[e] = 1'b0;
				uptodate[e] = 1'b0;
				push_result(bbcm_pkg::KIND_GRANT, 5'(e), dev, blk, 1'b0, 1'b0, 1'b1);
			end
			bbcm_pkg::MODE_RELEASE: begin
				if (refs[idx] == 0) begin
					push_result(bbcm_pkg::KIND_RELERR, '0, '0, '0, 1'b0, 1'b0, 1'b1);
				end else begin
					refs[idx]--;
					push_result(bbcm_pkg::KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
				end
			end
			bbcm_pkg::MODE_FLAGS: begin
				dirty[idx] = req[39];
				uptodate[idx] = req[40];
				push_result(bbcm_pkg::KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
			end
			default: begin
				flush_dirty(dev == 0, dev);
				push_result(bbcm_pkg::KIND_DONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	function void report(string what);
		$display("mismatch: %s", what);
		errors++;
	endfunction

	// compare one accepted result with the oldest prediction
	function void check_result(logic [47:0] d, logic lst);
		logic [47:0] want;
		bit want_last;
		if (pending_data.size() == 0) begin
			report($sformatf("unexpected result %h", d));
			return;
		end
		want = pending_data.pop_front();
		want_last = pending_last.pop_front();
		if (d[2:0] !== want[2:0])
			report($sformatf("kind %0d want %0d", d[2:0], want[2:0]));
		if (d[7:3] !== want[7:3])
			report($sformatf("result_index %0d want %0d", d[7:3], want[7:3]));
		if (d[23:8] !== want[23:8])
			report($sformatf("result_device %h want %h", d[23:8], want[23:8]));
		if (d[39:24] !== want[39:24])
			report($sformatf("result_block %h want %h", d[39:24], want[39:24]));
		if (d[40] !== want[40])
			report($sformatf("was_hit %b want %b", d[40], want[40]));
		if (d[41] !== want[41])
			report($sformatf("holds_valid_data %b want %b", d[41], want[41]));
		if (d[47:42] !== '0)
			report($sformatf("padding %h not zero", d[47:42]));
		if (lst !== want_last)
			report($sformatf("last %b want %b", lst, want_last));
	endfunction
endclass

module tb_block_buffer_cache_manager;
	import bbcm_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;

	bbcm_scoreboard cache_model = new();
	int             out_wait = 0;

	// small pools so that gets hit, collide and run the cache full
	logic [15:0] dev_pool [4] = '{16'h0001, 16'h0002, 16'hffff, 16'h8000};

	always #10 clk = ~clk;

	block_buffer_cache_manager i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// send one request after a random gap and wait for its acceptance
	task automatic send_request(mode_t m, logic [15:0] dev, logic [15:0] blk,
			logic [4:0] idx, bit dflag, bit vflag);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {7'b0, vflag, dflag, idx, blk, dev, m};
		s_axis_tvalid <= 1;
		do @(posedge clk); while (!s_axis_tready);
		cache_model.note_request(s_axis_tdata);
	endtask

	// random request; gets are the most frequent kind and use a small set of tags
	task automatic send_random();
		int r;
		logic [15:0] dev, blk;
		r = $urandom_range(0, 99);
		dev = dev_pool[$urandom_range(0, 3)];
		blk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
		if (r < 45)
			send_request(MODE_GET, ($urandom_range(0, 19) == 0) ? 16'h0 : dev, blk,
				5'($urandom), 1'($urandom), 1'($urandom));
		else if (r < 70)
			send_request(MODE_RELEASE, 16'($urandom), 16'($urandom), 5'($urandom),
				1'($urandom), 1'($urandom));
		else if (r < 90)
			send_request(MODE_FLAGS, 16'($urandom), 16'($urandom), 5'($urandom),
				1'($urandom), 1'($urandom));
		else
			send_request(MODE_SYNC, ($urandom_range(0, 3) == 0) ? 16'h0 : dev,
				16'($urandom), 5'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// result side: a random wait after each accepted result before the next is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				cache_model.check_result(m_axis_tdata, m_axis_tlast);
				out_wait = $urandom_range(0, 9);
			end else if (out_wait > 0) begin
				out_wait--;
			end
			m_axis_tready <= (out_wait == 0);
		end
	end

	// stimulus: directed corners then random traffic
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// corner fields, release error on an idle entry, hit and miss
		send_request(MODE_RELEASE, 16'h0, 16'h0, 5'd31, 1'b0, 1'b0);
		send_request(MODE_GET, 16'hffff, 16'hffff, 5'd0, 1'b0, 1'b0);
		send_request(MODE_GET, 16'hffff, 16'hffff, 5'd0, 1'b0, 1'b0);
		send_request(MODE_GET, 16'h0, 16'h0, 5'd0, 1'b0, 1'b0);
		send_request(MODE_FLAGS, 16'hffff, 16'hffff, 5'd0, 1'b1, 1'b1);
		send_request(MODE_FLAGS, 16'h0, 16'h0, 5'd1, 1'b1, 1'b0);
		send_request(MODE_GET, 16'hffff, 16'hffff, 5'd0, 1'b0, 1'b0);
		send_request(MODE_SYNC, 16'hffff, 16'h0, 5'd0, 1'b0, 1'b0);
		send_request(MODE_FLAGS, 16'h0, 16'h0, 5'd31, 1'b1, 1'b1);
		send_request(MODE_SYNC, 16'h0, 16'hffff, 5'd31, 1'b1, 1'b1);
		send_request(MODE_RELEASE, 16'h0, 16'h0, 5'd0, 1'b0, 1'b0);
		send_request(MODE_RELEASE, 16'h0, 16'h0, 5'd0, 1'b0, 1'b0);
		// fill every entry so the next get finds none free
		for (int i = 0; i < 32; i++)
			send_request(MODE_GET, 16'h0002, 16'(i + 100), 5'd0, 1'b0, 1'b0);
		send_request(MODE_GET, 16'h0002, 16'h1234, 5'd0, 1'b0, 1'b0);
		// dirty every odd-numbered entry, free entry 4 and get a new tag into it
		for (int i = 0; i < 32; i++)
			send_request(MODE_FLAGS, 16'h0, 16'h0, 5'(i), i[0], 1'b1);
		send_request(MODE_RELEASE, 16'h0, 16'h0, 5'd4, 1'b0, 1'b0);
		send_request(MODE_GET, 16'h0003, 16'h0001, 5'd0, 1'b0, 1'b0);
		for (int i = 0; i < 32; i++)
			send_request(MODE_RELEASE, 16'h0, 16'h0, 5'(i), 1'b0, 1'b0);
		// random traffic
		repeat (270) send_random();
		s_axis_tvalid <= 0;
		while (cache_model.pending_data.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (cache_model.errors == 0 && cache_model.pending_data.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
